@@ rtl/core/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared defaults, operation codes and result kinds.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;
    localparam int DEF_TIME_BITS   = 32;

    // Operation carried by an input beat.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Kind of a result beat.
    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_DROPPED  = 2'd1,
        KIND_FIRED    = 2'd2
    } t_kind;

endpackage

@@ rtl/core/dtq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/dtq_unit.sv @@
// ----------------------------------------------------------------------------
// Shared address and compare unit
// Maps a queue position to a RAM address around the ring and compares a
// stored due time against the current key.
// ----------------------------------------------------------------------------
module dtq_unit #(
    parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int SW = $clog2(2 * QUEUE_DEPTH)
) (
    input  logic [AW-1:0]        i_head,
    input  logic [CW-1:0]        i_index,
    input  logic [TIME_BITS-1:0] i_due,
    input  logic [TIME_BITS-1:0] i_key,
    output logic [AW-1:0]        o_addr,
    output logic                 o_due_le
);

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    // The sum stays below twice the depth, so one subtract folds it back.
    always_comb begin
        sum = SW'(i_head) + SW'(i_index);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            wrapped = sum - SW'(QUEUE_DEPTH);
        end else begin
            wrapped = sum;
        end
    end

    assign o_addr   = wrapped[AW-1:0];
    assign o_due_le = (i_due <= i_key);

endmodule

@@ rtl/core/deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue
// Holds pending tasks in due-time order and releases the due ones on a tick.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Payload
//  input     in   i_valid / o_stall  i_opcode, i_task_id, i_due_time, i_now_time
//  result    out  o_valid / i_stall  o_kind, o_task_id_out, o_due_time_out, o_last
//
//  An add moves each later task up one slot and then writes the new task; when
//  the queue is full it drops the task. A tick pops the due tasks from the head
//  and sends nothing when none is due. Entries pass one at a time through the
//  one RAM read port and shared compare unit. Reset clears the sequencer, count,
//  head, pending flag and result valid; a result stall can hold the sequencer,
//  and the input stays stalled until the last beat, if any, loads.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = dtq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = dtq_pkg::DEF_ID_BITS,
    parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [ID_BITS-1:0]   i_task_id,
    input  logic [TIME_BITS-1:0] i_due_time,
    input  logic [TIME_BITS-1:0] i_now_time,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [ID_BITS-1:0]   o_task_id_out,
    output logic [TIME_BITS-1:0] o_due_time_out,
    output logic                 o_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = ID_BITS + TIME_BITS;

    // Sequencer states. Add walks from the tail toward the head, moving
    // later tasks up by one place until the new task's slot is found. Tick
    // pops from the head while the head task is due; a popped task is held
    // back one step so that its last marker is known when it is sent.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_WR,
        S_TICK_RD,
        S_TICK_CMP,
        S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_hole, n_hole;
    logic [TIME_BITS-1:0]  r_key, n_key;
    logic [ID_BITS-1:0]    r_new_id, n_new_id;
    // Result held back until the next one or the end is known.
    logic                  r_pend, n_pend;
    dtq_pkg::t_kind        r_pend_kind, n_pend_kind;
    logic [ID_BITS-1:0]    r_pend_id, n_pend_id;
    logic [TIME_BITS-1:0]  r_pend_due, n_pend_due;
    // Result register toward the output channel.
    logic                  r_out_valid;
    dtq_pkg::t_kind        r_out_kind;
    logic [ID_BITS-1:0]    r_out_id;
    logic [TIME_BITS-1:0]  r_out_due;
    logic                  r_out_last;

    logic                  push;
    logic                  push_last;
    logic                  out_free;

    logic [CW-1:0]         u_index;
    logic [AW-1:0]         u_addr;
    logic                  u_due_le;

    logic                  ram_wr_en;
    logic [EW-1:0]         ram_wr_data;
    logic                  ram_rd_en;
    logic [EW-1:0]         ram_rd_data;
    logic [ID_BITS-1:0]    rd_id;
    logic [TIME_BITS-1:0]  rd_due;

    assign rd_id  = ram_rd_data[EW-1:TIME_BITS];
    assign rd_due = ram_rd_data[TIME_BITS-1:0];

    // The result register can take a new beat when it is empty or when its
    // current beat leaves at this edge.
    assign out_free = !r_out_valid || !i_stall;

    // Task storage: one entry per ring slot, identifier above due time.
    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (u_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (u_addr),
        .o_rd_data (ram_rd_data)
    );

    // The one address and compare unit, steered by the sequencer.
    dtq_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_unit (
        .i_head   (r_head),
        .i_index  (u_index),
        .i_due    (rd_due),
        .i_key    (r_key),
        .o_addr   (u_addr),
        .o_due_le (u_due_le)
    );

    // Which queue position the unit addresses in each state. While popping,
    // position one becomes the new head.
    always_comb begin
        unique case (r_state) inside
            S_ADD_RD:   u_index = r_hole - CW'(1);
            S_ADD_CMP,
            S_ADD_WR:   u_index = r_hole;
            S_TICK_CMP: u_index = CW'(1);
            default:    u_index = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_hole      = r_hole;
        n_key       = r_key;
        n_new_id    = r_new_id;
        n_pend      = r_pend;
        n_pend_kind = r_pend_kind;
        n_pend_id   = r_pend_id;
        n_pend_due  = r_pend_due;
        push        = 1'b0;
        push_last   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_data = {r_new_id, r_key};
        ram_rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_opcode == dtq_pkg::OP_ADD) begin
                        n_key    = i_due_time;
                        n_new_id = i_task_id;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            // Queue is full: echo the task back as dropped.
                            n_pend      = 1'b1;
                            n_pend_kind = dtq_pkg::KIND_DROPPED;
                            n_pend_id   = i_task_id;
                            n_pend_due  = i_due_time;
                            n_state     = S_FIN;
                        end else begin
                            n_hole  = r_count;
                            n_state = S_ADD_RD;
                        end
                    end else begin
                        n_key   = i_now_time;
                        n_state = S_TICK_RD;
                    end
                end
            end

            S_ADD_RD: begin
                if (r_hole == '0) begin
                    n_state = S_ADD_WR;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_ADD_CMP;
                end
            end

            S_ADD_CMP: begin
                if (u_due_le) begin
                    // Entry below the hole is due no later: the hole is the slot.
                    n_state = S_ADD_WR;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    n_hole      = r_hole - CW'(1);
                    n_state     = S_ADD_RD;
                end
            end

            S_ADD_WR: begin
                ram_wr_en   = 1'b1;
                n_count     = r_count + CW'(1);
                n_pend      = 1'b1;
                n_pend_kind = dtq_pkg::KIND_ACCEPTED;
                n_pend_id   = r_new_id;
                n_pend_due  = r_key;
                n_state     = S_FIN;
            end

            S_TICK_RD: begin
                if (r_count == '0) begin
                    n_state = r_pend ? S_FIN : S_IDLE;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_TICK_CMP;
                end
            end

            S_TICK_CMP: begin
                if (u_due_le) begin
                    // Another task is due, so the held one is not the last.
                    if (!r_pend || out_free) begin
                        push        = r_pend;
                        n_pend      = 1'b1;
                        n_pend_kind = dtq_pkg::KIND_FIRED;
                        n_pend_id   = rd_id;
                        n_pend_due  = rd_due;
                        n_head      = u_addr;
                        n_count     = r_count - CW'(1);
                        n_state     = S_TICK_RD;
                    end
                end else begin
                    n_state = r_pend ? S_FIN : S_IDLE;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend    = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_hole      <= n_hole;
        r_key       <= n_key;
        r_new_id    <= n_new_id;
        r_pend_kind <= n_pend_kind;
        r_pend_id   <= n_pend_id;
        r_pend_due  <= n_pend_due;
        if (push) begin
            r_out_kind <= r_pend_kind;
            r_out_id   <= r_pend_id;
            r_out_due  <= r_pend_due;
            r_out_last <= push_last;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_task_id_out  = r_out_id;
    assign o_due_time_out = r_out_due;
    assign o_last         = r_out_last;

endmodule

@@ rtl/core/dtq_checker.sv @@
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker #(
    parameter int ID_BITS   = dtq_pkg::DEF_ID_BITS,
    parameter int TIME_BITS = dtq_pkg::DEF_TIME_BITS
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [1:0]           o_kind,
    input logic [ID_BITS-1:0]   o_task_id_out,
    input logic [TIME_BITS-1:0] o_due_time_out,
    input logic                 o_last
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_task_id_out)
            && $stable(o_due_time_out) && $stable(o_last))
        else $error("result beat changed while stalled");

    // An add answers with exactly one beat, so that beat carries the marker.
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == dtq_pkg::KIND_ACCEPTED || o_kind == dtq_pkg::KIND_DROPPED)
            |-> o_last)
        else $error("add result without last marker");

    // An accepted input beat keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after an accepted beat");

    // While a non-final fired beat is waiting, the burst is still being sent.
    a_busy_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("block idle in the middle of a fired burst");

endmodule

bind deadline_timer_queue dtq_checker #(
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
) u_dtq_checker (.*);

@@ tb/deadline_timer_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives add and tick beats into the queue with bursty traffic and a stalling
// result side. A scoreboard keeps its own sorted schedule, predicts every
// acknowledge and fired-task beat, and compares each result field by field.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;

    localparam int DEPTH      = dtq_pkg::DEF_QUEUE_DEPTH;
    localparam int IDW        = dtq_pkg::DEF_ID_BITS;
    localparam int TW         = dtq_pkg::DEF_TIME_BITS;
    localparam int RANDOM_CMD = 170;
    localparam int SETTLE_CYC = 120;
    localparam int HOLDOFF    = 400;

    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

    // One command for the driver. A drain_wait entry carries no beat: the
    // driver parks on it until every predicted result has been seen.
    typedef struct {
        logic           drain_wait;
        logic           opcode;
        logic [IDW-1:0] task_id;
        logic [TW-1:0]  due_time;
        logic [TW-1:0]  now_time;
    } t_sched_cmd;

    // One predicted result beat.
    typedef struct {
        dtq_pkg::t_kind kind;
        logic [IDW-1:0] task_id;
        logic [TW-1:0]  due_time;
        logic           last;
    } t_report;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_valid    = 1'b0;
    logic           i_opcode   = dtq_pkg::OP_ADD;
    logic [IDW-1:0] i_task_id  = '0;
    logic [TW-1:0]  i_due_time = '0;
    logic [TW-1:0]  i_now_time = '0;
    logic           i_stall    = 1'b0;
    logic           o_stall;
    logic           o_valid;
    logic [1:0]     o_kind;
    logic [IDW-1:0] o_task_id_out;
    logic [TW-1:0]  o_due_time_out;
    logic           o_last;

    // Pending commands for the driver, and results the queue still owes us.
    t_sched_cmd cmd_q[$];
    t_report    due_reports[$];

    // Scoreboard copy of the schedule: slots 0..sched_count-1, earliest first.
    logic [IDW-1:0] sched_id[DEPTH];
    logic [TW-1:0]  sched_due[DEPTH];
    int             sched_count = 0;

    int beats_fed  = 0;
    int fail_count = 0;
    int cmds_made  = 0;

    deadline_timer_queue #(
        .QUEUE_DEPTH (DEPTH),
        .ID_BITS     (IDW),
        .TIME_BITS   (TW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_task_id      (i_task_id),
        .i_due_time     (i_due_time),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_task_id_out  (o_task_id_out),
        .o_due_time_out (o_due_time_out),
        .o_last         (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Scoreboard schedule
    // ------------------------------------------------------------------------

    function automatic void post_report(dtq_pkg::t_kind kind, logic [IDW-1:0] id,
                                        logic [TW-1:0] due, logic last);
        t_report r;
        r.kind     = kind;
        r.task_id  = id;
        r.due_time = due;
        r.last     = last;
        due_reports.push_back(r);
    endfunction

    // Applies one accepted beat to the schedule and queues the results it owes.
    // A new task goes behind every task due at or before it, so equal due
    // times leave in the order they came in. A tick fires the due prefix.
    function automatic void advance_schedule(t_sched_cmd c);
        int pos;
        int fired;
        int k;
        if (c.opcode == dtq_pkg::OP_ADD) begin
            if (sched_count >= DEPTH) begin
                post_report(dtq_pkg::KIND_DROPPED, c.task_id, c.due_time, 1'b1);
            end else begin
                pos = 0;
                while (pos < sched_count && sched_due[pos] <= c.due_time)
                    pos++;
                for (k = sched_count; k > pos; k--) begin
                    sched_id[k]  = sched_id[k-1];
                    sched_due[k] = sched_due[k-1];
                end
                sched_id[pos]  = c.task_id;
                sched_due[pos] = c.due_time;
                sched_count++;
                post_report(dtq_pkg::KIND_ACCEPTED, c.task_id, c.due_time, 1'b1);
            end
        end else begin
            fired = 0;
            while (fired < sched_count && sched_due[fired] <= c.now_time)
                fired++;
            for (k = 0; k < fired; k++)
                post_report(dtq_pkg::KIND_FIRED, sched_id[k], sched_due[k],
                            k == fired - 1);
            for (k = 0; k + fired < sched_count; k++) begin
                sched_id[k]  = sched_id[k+fired];
                sched_due[k] = sched_due[k+fired];
            end
            sched_count -= fired;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Command builders. Fields that the operation ignores get random values
    // so that every input bit moves.
    // ------------------------------------------------------------------------

    function automatic void push_add(logic [IDW-1:0] id, logic [TW-1:0] due);
        t_sched_cmd c;
        c.drain_wait = 1'b0;
        c.opcode     = dtq_pkg::OP_ADD;
        c.task_id    = id;
        c.due_time   = due;
        c.now_time   = TW'($urandom);
        cmd_q.push_back(c);
        cmds_made++;
    endfunction

    function automatic void push_tick(logic [TW-1:0] now);
        t_sched_cmd c;
        c.drain_wait = 1'b0;
        c.opcode     = dtq_pkg::OP_TICK;
        c.task_id    = IDW'($urandom);
        c.due_time   = TW'($urandom);
        c.now_time   = now;
        cmd_q.push_back(c);
        cmds_made++;
    endfunction

    function automatic void push_drain_wait();
        t_sched_cmd c;
        c.drain_wait = 1'b1;
        c.opcode     = dtq_pkg::OP_ADD;
        c.task_id    = '0;
        c.due_time   = '0;
        c.now_time   = '0;
        cmd_q.push_back(c);
    endfunction

    // ------------------------------------------------------------------------
    // Driver. It works in bursts of random length separated by random gaps;
    // a gap of zero gives back-to-back stretches. A beat that is stalled
    // keeps its payload until the queue takes it.
    // ------------------------------------------------------------------------

    t_sched_cmd cur_cmd;
    int         burst_left = 1;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_opcode   <= dtq_pkg::OP_ADD;
            i_task_id  <= '0;
            i_due_time <= '0;
            i_now_time <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_schedule(cur_cmd);
                beats_fed <= beats_fed + 1;
            end
            if (i_valid && o_stall) begin
                // Hold the beat as it is.
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (cmd_q.size() != 0 && cmd_q[0].drain_wait) begin
                // Pause the sender until the queue has paid out everything.
                i_valid <= 1'b0;
                if (due_reports.size() == 0)
                    void'(cmd_q.pop_front());
            end else if (cmd_q.size() != 0) begin
                cur_cmd = cmd_q.pop_front();
                i_valid    <= 1'b1;
                i_opcode   <= cur_cmd.opcode;
                i_task_id  <= cur_cmd.task_id;
                i_due_time <= cur_cmd.due_time;
                i_now_time <= cur_cmd.now_time;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side stall. The pattern switches at random among no stall,
    // alternating stall, light random and heavy random. Twice during
    // the run it holds off for a long stretch so that the queue backs up and
    // stalls its input while the driver keeps offering beats.
    // ------------------------------------------------------------------------

    int stall_mode    = 0;
    int mode_cycles   = 0;
    int holdoff_left  = 0;
    int holdoffs_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_stall <= 1'b1;
            holdoff_left--;
        end else if (holdoffs_done < 2 && beats_fed >= 60 + holdoffs_done * 100) begin
            i_stall <= 1'b1;
            holdoff_left = HOLDOFF - 1;
            holdoffs_done++;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 3);
                mode_cycles = 50;
            end
            mode_cycles--;
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= mode_cycles[0];
                end
                2: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result beat taken is matched against the oldest
    // prediction; a beat with nothing predicted is a failure on its own.
    // ------------------------------------------------------------------------

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind %0d id %0h due %0h",
                         $time, o_kind, o_task_id_out, o_due_time_out);
                fail_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_kind));
                check_field("task_id_out", 64'(want.task_id), 64'(o_task_id_out));
                check_field("due_time_out", 64'(want.due_time), 64'(o_due_time_out));
                check_field("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------

    initial begin
        logic [TW-1:0] base;
        int            seq_no;
        int            n_add;
        int            n_tick;
        int            k;

        // Directed part: empty tick, extreme ids and times, a tie, partial
        // firing, filling the queue with descending dues so every insert
        // shifts the whole schedule, a drop when full, and a tick at the
        // largest time that fires all sixteen entries.
        push_tick('0);
        push_add('0, '0);
        push_add({IDW{1'b1}}, TIME_MAX);
        push_add(8'h5a, 32'd100);
        push_add(8'ha5, 32'd100);
        push_add(8'h33, 32'd50);
        push_tick(32'd49);
        push_tick(32'd100);
        for (k = 0; k < DEPTH - 1; k++)
            push_add(IDW'(8'h10 + k), TW'(32'hffff_fff0 - k));
        push_add(8'hc3, 32'd7);
        push_tick(TIME_MAX);
        push_drain_wait();

        // Random part: mostly well-formed runs of adds clustered around a
        // base time with ties and overflow, followed by rising ticks. About
        // one run in ten is pure noise over the full field ranges.
        seq_no = 0;
        while (cmds_made < 25 + RANDOM_CMD) begin
            seq_no++;
            if ($urandom_range(0, 9) == 0) begin
                n_add = $urandom_range(1, 4);
                for (k = 0; k < n_add; k++) begin
                    if ($urandom_range(0, 1) == 0)
                        push_add(IDW'($urandom), TW'($urandom));
                    else
                        push_tick(TW'($urandom));
                end
            end else begin
                base  = ($urandom_range(0, 3) == 0) ? TW'($urandom)
                                                    : TW'($urandom_range(0, 5000));
                n_add = $urandom_range(1, 20);
                for (k = 0; k < n_add; k++) begin
                    push_add(IDW'($urandom), TW'(base + $urandom_range(0, 24)));
                    if ($urandom_range(0, 5) == 0)
                        push_tick(TW'(base + $urandom_range(0, 12)));
                end
                n_tick = $urandom_range(1, 4);
                for (k = 0; k < n_tick; k++)
                    push_tick(TW'(base + k * 8 + $urandom_range(0, 7)));
                if ($urandom_range(0, 1) == 0)
                    push_tick(TIME_MAX);
                else
                    push_tick(TW'(base + 40));
            end
            if (seq_no % 7 == 0)
                push_drain_wait();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the driver to hand over every beat, then for the queue to
        // pay out every result, then a little longer to catch strays.
        while (cmd_q.size() != 0 || i_valid)
            @(posedge i_clk);
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (fail_count == 0)
            $display("deadline_timer_queue_tb: PASS");
        else
            $display("deadline_timer_queue_tb: FAIL");
        $finish;
    end

    // Hard limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("deadline_timer_queue_tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_ram.sv
rtl/core/dtq_unit.sv
rtl/core/deadline_timer_queue.sv
rtl/core/dtq_checker.sv
tb/deadline_timer_queue_tb.sv
